// ===== src/lbft_pkg.sv =====
// ----------------------------------------------------------------------------
// lbft_pkg
// Shared widths, codes and record types of the log-binned fluence tally.
// ----------------------------------------------------------------------------
package lbft_pkg;

   // field widths
   localparam int CMD_W = 2;
   localparam int E_W   = 24;
   localparam int REG_W = 8;
   localparam int LEN_W = 32;
   localparam int KEY_W = 14;
   localparam int SUM_W = 48;

   // tally store geometry
   localparam int STORE_DEPTH = 1 << KEY_W;
   localparam logic [KEY_W-1:0] KEY_LAST = {KEY_W{1'b1}};
   localparam logic [SUM_W-1:0] FULL_SCALE = {SUM_W{1'b1}};
   localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

   // request command codes
   localparam logic [CMD_W-1:0] CMD_SCORE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // classified request kind
   typedef enum logic [1:0] {
      KIND_SCORE,
      KIND_READ,
      KIND_CLEAR,
      KIND_DROP
   } kind_type;

   // one unit of work for the back end
   typedef struct packed {
      kind_type            kind;
      logic [KEY_W-1:0]    key;
      logic [LEN_W-1:0]    length;
   } work_type;

   // one response record
   typedef struct packed {
      logic                scored;
      logic [KEY_W-1:0]    entry_key;
      logic [SUM_W-1:0]    tally_value;
      logic                saturated;
   } result_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_CLEAR_DONE,
      ST_IDLE,
      ST_CALC
   } back_state_type;

endpackage

// ===== src/lbft_req_if.sv =====
// ----------------------------------------------------------------------------
// lbft_req_if
// Request channel: valid/ready handshake carrying one particle step or command.
// ----------------------------------------------------------------------------
interface lbft_req_if;
   logic                        valid;
   logic                        ready;
   logic [lbft_pkg::CMD_W-1:0]  command;
   logic                        is_photon;
   logic [lbft_pkg::E_W-1:0]    energy_kev;
   logic [lbft_pkg::REG_W-1:0]  region_id;
   logic [lbft_pkg::LEN_W-1:0]  step_length;
   logic [lbft_pkg::KEY_W-1:0]  read_key;

   modport source (
      output valid, command, is_photon, energy_kev, region_id, step_length, read_key,
      input  ready
   );

   modport sink (
      input  valid, command, is_photon, energy_kev, region_id, step_length, read_key,
      output ready
   );
endinterface

// ===== src/lbft_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lbft_rsp_if
// Response channel: valid/ready handshake carrying one tally result.
// ----------------------------------------------------------------------------
interface lbft_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        scored;
   logic [lbft_pkg::KEY_W-1:0]  entry_key;
   logic [lbft_pkg::SUM_W-1:0]  tally_value;
   logic                        saturated;

   modport source (
      output valid, scored, entry_key, tally_value, saturated,
      input  ready
   );

   modport sink (
      input  valid, scored, entry_key, tally_value, saturated,
      output ready
   );
endinterface

// ===== src/log_binned_fluence_tally.sv =====
// ----------------------------------------------------------------------------
// log_binned_fluence_tally
// Photon track-length tally keyed by region and logarithmic energy bin.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per handshake: score a step, read an entry
//   or clear the whole table. rsp_ch returns exactly one response per
//   request, in request order. Rejected steps, clears and unused commands
//   answer with an all-zero response.
//   The front end bins the energy against constant edges in one register
//   stage and forms the key behind it; a two-entry queue feeds the back end,
//   which owns the tally store.
//   A request passes the front-end stage register, the queue, the registered
//   store read and the response register. The back end finishes each score or
//   read before it takes the next: the store read is followed by the update.
//   A clear sweeps the store one entry per cycle until every entry is zero,
//   then answers with its response. Reset starts the same sweep; the
//   front end keeps taking requests until the queue fills.
//   When rsp_ch stalls the response is held in its output register, the back
//   end waits with the next item, and the queue and front end fill before
//   req_ch.ready falls.
// ----------------------------------------------------------------------------
module log_binned_fluence_tally #(
   parameter int BINS     = 64,
   parameter int REGIONS  = 256,
   parameter int EMIN_KEV = 1,
   parameter int EMAX_KEV = 10000
) (
   input  logic         clock,
   input  logic         reset,
   lbft_req_if.sink     req_ch,
   lbft_rsp_if.source   rsp_ch
);
   import lbft_pkg::*;

   logic      push_valid;
   logic      push_ready;
   work_type  push_data;
   logic      pop_valid;
   logic      pop_ready;
   work_type  pop_data;

   // binning and classification
   lbft_front #(
      .BINS     (BINS),
      .REGIONS  (REGIONS),
      .EMIN_KEV (EMIN_KEV),
      .EMAX_KEV (EMAX_KEV)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   lbft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // tally store and response
   lbft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== src/lbft_front.sv =====
// ----------------------------------------------------------------------------
// lbft_front
// Accepts requests, finds the logarithmic energy bin against constant edges,
// classifies each request and forms the tally key for the back end.
// ----------------------------------------------------------------------------
module lbft_front #(
   parameter int BINS     = 64,
   parameter int REGIONS  = 256,
   parameter int EMIN_KEV = 1,
   parameter int EMAX_KEV = 10000
) (
   input  logic                 clock,
   input  logic                 reset,
   lbft_req_if.sink             req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output lbft_pkg::work_type   push_data
);
   import lbft_pkg::*;

   localparam int CNT_W  = $clog2(BINS + 1);
   localparam int BIN_W  = $clog2(BINS);
   localparam int PROD_W = (REG_W + CNT_W + 1 > KEY_W) ? REG_W + CNT_W + 1 : KEY_W;

   // primes for the exact-edge residue check
   localparam longint PRIME_A = 64'd2147483647;
   localparam longint PRIME_B = 64'd2147483629;
   localparam longint PRIME_C = 64'd2147483587;

   // modular product, operands below the chosen prime
   function automatic longint mul_mod(input longint a, input longint b, input int sel);
      longint p;
      p = a * b;
      case (sel)
         0:       return p % PRIME_A;
         1:       return p % PRIME_B;
         default: return p % PRIME_C;
      endcase
   endfunction

   // modular power by repeated product
   function automatic longint pow_mod(input longint base, input int ex, input int sel);
      longint acc;
      longint b;
      acc = 1;
      b   = mul_mod(base, 1, sel);
      for (int k = 0; k < ex; k++) begin
         acc = mul_mod(acc, b, sel);
      end
      return acc;
   endfunction

   // true when n^BINS equals EMIN^(BINS-idx) * EMAX^idx
   function automatic bit edge_is_exact(input longint n, input int idx);
      bit     same;
      longint lhs;
      longint rhs;
      same = 1'b1;
      for (int s = 0; s < 3; s++) begin
         lhs = pow_mod(n, BINS, s);
         rhs = mul_mod(pow_mod(EMIN_KEV, BINS - idx, s), pow_mod(EMAX_KEV, idx, s), s);
         if (lhs != rhs) same = 1'b0;
      end
      return same;
   endfunction

   // ceiling of the geometric edge, exact at integer edges
   function automatic logic [E_W-1:0] edge_value(input int idx);
      real    lr;
      real    x;
      longint n;
      longint c;
      lr = $ln(real'(EMAX_KEV)) - $ln(real'(EMIN_KEV));
      x  = real'(EMIN_KEV) * $exp(lr * real'(idx) / BINS);
      n  = longint'($floor(x + 0.5));
      if ((x - real'(n) < 1.0e-6 * x) && (real'(n) - x < 1.0e-6 * x) &&
          edge_is_exact(n, idx)) begin
         c = n;
      end else begin
         c = longint'($ceil(x));
      end
      if (c < 0) c = 0;
      if (c > longint'(E_MAX)) c = longint'(E_MAX);
      return c[E_W-1:0];
   endfunction

   // staged request after classification
   typedef struct packed {
      kind_type            kind;
      logic [REG_W-1:0]    region;
      logic [BIN_W-1:0]    bin;
      logic [LEN_W-1:0]    length;
      logic [KEY_W-1:0]    rkey;
   } stage_type;

   logic [BINS+1:0]   ge;
   logic [BINS:0]     last;
   logic [CNT_W-1:0]  bin_cnt;
   logic [BIN_W-1:0]  bin_sel;
   logic              step_ok;
   kind_type          kind_sel;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   stage_type         s1_ff;
   stage_type         s1_in;
   logic [PROD_W-1:0] key_prod;

   // compare against every edge in parallel
   assign ge[BINS+1] = 1'b0;
   for (genvar gi = 0; gi <= BINS; gi++) begin : g_edge
      localparam logic [E_W-1:0] EDGE = edge_value(gi);
      assign ge[gi] = (req_ch.energy_kev >= EDGE);
   end

   // top of the thermometer marks the bin
   assign last = ge[BINS:0] & ~ge[BINS+1:1];

   always_comb begin
      bin_cnt = '0;
      for (int i = 0; i <= BINS; i++) begin
         if (last[i]) bin_cnt = bin_cnt | CNT_W'(i);
      end
   end

   // clamp to the last bin
   assign bin_sel = (bin_cnt >= CNT_W'(BINS)) ? BIN_W'(BINS - 1) : bin_cnt[BIN_W-1:0];

   // step qualification
   assign step_ok = req_ch.is_photon && (req_ch.step_length != '0) &&
                    (32'(req_ch.region_id) < 32'(REGIONS)) &&
                    (req_ch.energy_kev >= E_W'(EMIN_KEV)) &&
                    (req_ch.energy_kev <= E_W'(EMAX_KEV));

   // command classification
   always_comb begin
      case (req_ch.command)
         CMD_SCORE: kind_sel = step_ok ? KIND_SCORE : KIND_DROP;
         CMD_READ:  kind_sel = KIND_READ;
         CMD_CLEAR: kind_sel = KIND_CLEAR;
         default:   kind_sel = KIND_DROP;
      endcase
   end

   // stage register, advances when empty or draining into the queue, closed in reset
   assign req_ch.ready = !reset && (!s1_valid_ff || push_ready);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_ch.ready) begin
         s1_valid_in  = req_ch.valid;
         s1_in.kind   = kind_sel;
         s1_in.region = req_ch.region_id;
         s1_in.bin    = bin_sel;
         s1_in.length = req_ch.step_length;
         s1_in.rkey   = req_ch.read_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_ff <= s1_in;
   end

   // key formation: region times bin count plus bin
   assign key_prod = PROD_W'(s1_ff.region) * PROD_W'(BINS) + PROD_W'(s1_ff.bin);

   assign push_valid       = s1_valid_ff;
   assign push_data.kind   = s1_ff.kind;
   assign push_data.key    = (s1_ff.kind == KIND_READ) ? s1_ff.rkey : key_prod[KEY_W-1:0];
   assign push_data.length = s1_ff.length;

endmodule

// ===== src/lbft_queue.sv =====
// ----------------------------------------------------------------------------
// lbft_queue
// Short first-in first-out queue of work records between front and back end.
// ----------------------------------------------------------------------------
module lbft_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  lbft_pkg::work_type   push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output lbft_pkg::work_type   pop_data
);
   import lbft_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/lbft_back.sv =====
// ----------------------------------------------------------------------------
// lbft_back
// Tally store sequencer: read-modify-write of one entry per score, entry
// reads, and the clearing sweep after reset and on a clear command.
// ----------------------------------------------------------------------------
module lbft_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  lbft_pkg::work_type   pop_data,
   lbft_rsp_if.source           rsp_ch
);
   import lbft_pkg::*;

   logic [SUM_W-1:0]  tally_mem [STORE_DEPTH];
   logic [SUM_W-1:0]  rdata_ff;
   logic              mem_we;
   logic [KEY_W-1:0]  mem_waddr;
   logic [SUM_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [KEY_W-1:0]  mem_raddr;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [KEY_W-1:0]  clear_ptr_ff;
   logic [KEY_W-1:0]  clear_ptr_in;
   logic              from_cmd_ff;
   logic              from_cmd_in;
   work_type          cur_ff;
   work_type          cur_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_data_ff;
   result_type        rsp_data_in;

   logic              rsp_free;
   logic              load;
   result_type        res;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;
   logic              sum_over;

   // tally store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tally_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= tally_mem[mem_raddr];
      end
   end

   // saturating accumulate
   assign sum_wide = {1'b0, rdata_ff} + (SUM_W + 1)'(cur_ff.length);
   assign sum_over = sum_wide[SUM_W];
   assign sum_sat  = sum_over ? FULL_SCALE : sum_wide[SUM_W-1:0];

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer next state and controls
   always_comb begin
      state_in     = state_ff;
      clear_ptr_in = clear_ptr_ff;
      from_cmd_in  = from_cmd_ff;
      cur_in       = cur_ff;
      pop_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff.key;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = pop_data.key;
      load         = 1'b0;
      res          = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_ptr_ff;
            clear_ptr_in = clear_ptr_ff + 1'b1;
            if (clear_ptr_ff == KEY_LAST) begin
               state_in = from_cmd_ff ? ST_CLEAR_DONE : ST_IDLE;
            end
         end
         ST_CLEAR_DONE: begin
            if (rsp_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in = pop_data;
               case (pop_data.kind)
                  KIND_CLEAR: begin
                     state_in     = ST_CLEAR;
                     from_cmd_in  = 1'b1;
                     clear_ptr_in = '0;
                  end
                  default: begin
                     mem_re   = 1'b1;
                     state_in = ST_CALC;
                  end
               endcase
            end
         end
         ST_CALC: begin
            if (rsp_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               case (cur_ff.kind)
                  KIND_SCORE: begin
                     mem_we          = 1'b1;
                     mem_wdata       = sum_sat;
                     res.scored      = 1'b1;
                     res.entry_key   = cur_ff.key;
                     res.tally_value = sum_sat;
                     res.saturated   = sum_over;
                  end
                  KIND_READ: begin
                     res.entry_key   = cur_ff.key;
                     res.tally_value = rdata_ff;
                     res.saturated   = (rdata_ff == FULL_SCALE);
                  end
                  default: begin
                     res = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_data_in = load ? res : rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ptr_ff <= '0;
         from_cmd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         from_cmd_ff  <= from_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.scored      = rsp_data_ff.scored;
   assign rsp_ch.entry_key   = rsp_data_ff.entry_key;
   assign rsp_ch.tally_value = rsp_data_ff.tally_value;
   assign rsp_ch.saturated   = rsp_data_ff.saturated;

`ifndef ASSERT_OFF
   // work is only taken from the queue while idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |-> state_ff == ST_IDLE)
      else $error("queue popped outside idle state");

   // the clearing sweep walks the store one entry per cycle
   a_clear_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && clear_ptr_ff != KEY_LAST |=>
      state_ff == ST_CLEAR && clear_ptr_ff == $past(clear_ptr_ff) + 1'b1)
      else $error("clearing sweep skipped or stopped early");

   // only a score writes the store outside the sweep
   a_write_score: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff == ST_CALC |-> cur_ff.kind == KIND_SCORE && rsp_free)
      else $error("store written by a non-score request");

   // a saturated response carries full scale
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.saturated |-> rsp_data_ff.tally_value == FULL_SCALE)
      else $error("saturated response below full scale");
`endif

endmodule
